FILE: hdl/rrd_pkg.sv
`timescale 1ns / 1ps

package rrd_pkg;

   // Store sizes in bytes.
   localparam int RAM_BYTES = 65536;
   localparam int ROM_BYTES = 65536;

   // Each store is split into four byte lanes, so a word at any byte offset
   // touches one row in every lane.
   localparam int LANES    = 4;
   localparam int RAM_ROWS = (RAM_BYTES + LANES - 1) / LANES;
   localparam int ROM_ROWS = (ROM_BYTES + LANES - 1) / LANES;
   localparam int RAM_ROW_W = (RAM_ROWS > 1) ? $clog2(RAM_ROWS) : 1;
   localparam int ROM_ROW_W = (ROM_ROWS > 1) ? $clog2(ROM_ROWS) : 1;

   // The clearing pass after reset walks the rows of the larger store.
   localparam int CLR_ROWS = (RAM_ROWS > ROM_ROWS) ? RAM_ROWS : ROM_ROWS;
   localparam int CLR_W    = (CLR_ROWS > 1) ? $clog2(CLR_ROWS) : 1;

   // Field widths.
   localparam int ACT_W  = 3;
   localparam int ADDR_W = 32;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 17;
   localparam int STAT_W = 2;
   localparam int IDX_W  = 2;
   localparam int CMP_W  = ADDR_W + 1;

   // Request actions.
   localparam logic [ACT_W-1:0] ACT_RD_BYTE  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_RD_WORD  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_WR_BYTE  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_WR_WORD  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_LOAD_ROM = 3'd4;

   // Response status codes.
   localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
   localparam logic [STAT_W-1:0] ST_UNMAPPED    = 2'd1;
   localparam logic [STAT_W-1:0] ST_ROM_REFUSED = 2'd2;
   localparam logic [STAT_W-1:0] ST_PAST_END    = 2'd3;

   // Register indexes.
   localparam logic [IDX_W-1:0] CSR_RAM_BASE   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_RAM_LENGTH = 2'd1;
   localparam logic [IDX_W-1:0] CSR_ROM_BASE   = 2'd2;
   localparam logic [IDX_W-1:0] CSR_ROM_LENGTH = 2'd3;

   // Where the read data of a request comes from.
   localparam logic [1:0] SRC_NONE = 2'd0;
   localparam logic [1:0] SRC_RAM  = 2'd1;
   localparam logic [1:0] SRC_ROM  = 2'd2;

   localparam logic [DATA_W-1:0] UNMAPPED_BYTE = 32'h0000_00FF;

   // Lane commands for the RAM store.
   typedef struct packed {
      logic                            wr;
      logic [LANES-1:0]                lane_en;
      logic [LANES-1:0][RAM_ROW_W-1:0] row;
      logic [LANES-1:0][7:0]           data;
   } rrd_ram_cmd_type;

   // Lane commands for the ROM store.
   typedef struct packed {
      logic                            wr;
      logic [LANES-1:0]                lane_en;
      logic [LANES-1:0][ROM_ROW_W-1:0] row;
      logic [LANES-1:0][7:0]           data;
   } rrd_rom_cmd_type;

   // What the response stage needs to finish a request.
   typedef struct packed {
      logic [1:0]        src;
      logic              word;
      logic [1:0]        lane_lo;
      logic              data_ff;
      logic [STAT_W-1:0] status;
   } rrd_info_type;

endpackage

FILE: hdl/rrd_ram.sv
`timescale 1ns / 1ps

module rrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rrd_decode.sv
`timescale 1ns / 1ps

module rrd_decode import rrd_pkg::*; (
   input  logic [ACT_W-1:0]  action,
   input  logic [ADDR_W-1:0] address,
   input  logic [DATA_W-1:0] write_data,
   input  logic [ADDR_W-1:0] ram_base,
   input  logic [LEN_W-1:0]  ram_length,
   input  logic [ADDR_W-1:0] rom_base,
   input  logic [LEN_W-1:0]  rom_length,
   output rrd_ram_cmd_type   ram_cmd,
   output rrd_rom_cmd_type   rom_cmd,
   output rrd_info_type      info
);

   logic [ADDR_W-1:0]           ram_off;
   logic [ADDR_W-1:0]           rom_off;
   logic [CMP_W-1:0]            ram_len_cmp;
   logic [CMP_W-1:0]            rom_len_cmp;
   logic                        in_ram;
   logic                        in_rom;
   logic                        ram_fit;
   logic                        rom_fit;
   logic [LANES-1:0][1:0]       ram_k;
   logic [LANES-1:0][1:0]       rom_k;
   logic [LANES-1:0][ADDR_W-1:0] ram_b;
   logic [LANES-1:0][ADDR_W-1:0] rom_b;

   // Region offsets and range checks; lengths beyond the store size saturate.
   always_comb begin
      ram_off = address - ram_base;
      rom_off = address - rom_base;
      ram_len_cmp = (CMP_W'(ram_length) > CMP_W'(RAM_BYTES)) ? CMP_W'(RAM_BYTES)
                                                             : CMP_W'(ram_length);
      rom_len_cmp = (CMP_W'(rom_length) > CMP_W'(ROM_BYTES)) ? CMP_W'(ROM_BYTES)
                                                             : CMP_W'(rom_length);
      in_ram  = CMP_W'(ram_off) < ram_len_cmp;
      in_rom  = CMP_W'(rom_off) < rom_len_cmp;
      ram_fit = (CMP_W'(ram_off) + CMP_W'(3)) < ram_len_cmp;
      rom_fit = (CMP_W'(rom_off) + CMP_W'(3)) < rom_len_cmp;
   end

   // Lane j holds byte k of the word, k = (j - offset) mod 4. A byte access
   // uses only the lane of the offset, where k is zero. The action decode
   // follows, RAM taking priority over ROM except for the ROM load.
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         ram_k[j] = 2'(j) - ram_off[1:0];
         rom_k[j] = 2'(j) - rom_off[1:0];
         ram_b[j] = ram_off + ADDR_W'(ram_k[j]);
         rom_b[j] = rom_off + ADDR_W'(rom_k[j]);
         ram_cmd.row[j]  = ram_b[j][RAM_ROW_W+1:2];
         rom_cmd.row[j]  = rom_b[j][ROM_ROW_W+1:2];
         ram_cmd.data[j] = write_data[8*ram_k[j] +: 8];
         rom_cmd.data[j] = write_data[8*rom_k[j] +: 8];
      end

      ram_cmd.wr      = 1'b0;
      ram_cmd.lane_en = '0;
      rom_cmd.wr      = 1'b0;
      rom_cmd.lane_en = '0;
      info.src        = SRC_NONE;
      info.word       = 1'b0;
      info.lane_lo    = ram_off[1:0];
      info.data_ff    = 1'b0;
      info.status     = ST_OK;

      case (action)
         ACT_RD_BYTE: begin
            if (in_ram) begin
               info.src = SRC_RAM;
            end else if (in_rom) begin
               info.src     = SRC_ROM;
               info.lane_lo = rom_off[1:0];
            end else begin
               info.data_ff = 1'b1;
               info.status  = ST_UNMAPPED;
            end
         end
         ACT_RD_WORD: begin
            info.word = 1'b1;
            if (in_ram) begin
               if (ram_fit) begin
                  info.src = SRC_RAM;
               end else begin
                  info.status = ST_PAST_END;
               end
            end else if (in_rom) begin
               info.lane_lo = rom_off[1:0];
               if (rom_fit) begin
                  info.src = SRC_ROM;
               end else begin
                  info.status = ST_PAST_END;
               end
            end else begin
               info.status = ST_UNMAPPED;
            end
         end
         ACT_WR_BYTE: begin
            if (in_ram) begin
               ram_cmd.wr = 1'b1;
               ram_cmd.lane_en[ram_off[1:0]] = 1'b1;
            end else if (in_rom) begin
               info.status = ST_ROM_REFUSED;
            end else begin
               info.status = ST_UNMAPPED;
            end
         end
         ACT_WR_WORD: begin
            if (in_ram) begin
               if (ram_fit) begin
                  ram_cmd.wr      = 1'b1;
                  ram_cmd.lane_en = '1;
               end else begin
                  info.status = ST_PAST_END;
               end
            end else if (in_rom) begin
               info.status = ST_ROM_REFUSED;
            end else begin
               info.status = ST_UNMAPPED;
            end
         end
         ACT_LOAD_ROM: begin
            if (in_rom) begin
               rom_cmd.wr = 1'b1;
               rom_cmd.lane_en[rom_off[1:0]] = 1'b1;
            end else begin
               info.status = ST_UNMAPPED;
            end
         end
         default: begin
            info.status = ST_OK;
         end
      endcase
   end

endmodule

FILE: hdl/rrd_assemble.sv
`timescale 1ns / 1ps

module rrd_assemble import rrd_pkg::*; (
   input  rrd_info_type          info,
   input  logic [LANES-1:0][7:0] ram_lanes,
   input  logic [LANES-1:0][7:0] rom_lanes,
   output logic [DATA_W-1:0]     read_data
);

   logic [LANES-1:0][7:0] lanes;
   logic [LANES-1:0][7:0] bytes;

   // Pick the store, then rotate the lanes so that byte 0 is the lowest address.
   always_comb begin
      lanes = (info.src == SRC_ROM) ? rom_lanes : ram_lanes;
      for (int k = 0; k < LANES; k++) begin
         bytes[k] = lanes[2'(k) + info.lane_lo];
      end

      if (info.src == SRC_NONE) begin
         read_data = info.data_ff ? UNMAPPED_BYTE : '0;
      end else if (info.word) begin
         read_data = bytes;
      end else begin
         read_data = {24'b0, bytes[0]};
      end
   end

endmodule

FILE: hdl/ram_rom_region_decoder.sv
`timescale 1ns / 1ps

// RAM/ROM region decoder. Each request is a byte or little-endian word read
// or write, or a ROM load byte, decoded against one RAM and one ROM region
// (base and length each; RAM wins where they overlap, save for ROM loads).
// The block takes one request per clock unless the response side stalls it
// or the clearing pass runs, answering through the memory stage and output
// register; the rate is set by the four byte-lane memories of each store,
// which give one read and one write per cycle, so an unaligned word needs no
// second access. After reset a clearing pass zeroes both stores, one row of
// every lane per cycle; requests wait during it, but register writes do not.
module ram_rom_region_decoder import rrd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,   // address [31:0], write_data [63:32]
   input  logic [ACT_W-1:0]      req_tuser,   // action [2:0]
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,   // read_data [31:0]
   output logic [STAT_W-1:0]     rsp_tuser,   // status [1:0]
   // Register write port.
   input  logic                  csr_we,
   input  logic [IDX_W-1:0]      csr_index,
   input  logic [ADDR_W-1:0]     csr_wdata
);

   logic [ADDR_W-1:0] ram_base_ff,   ram_base_in;
   logic [LEN_W-1:0]  ram_length_ff, ram_length_in;
   logic [ADDR_W-1:0] rom_base_ff,   rom_base_in;
   logic [LEN_W-1:0]  rom_length_ff, rom_length_in;

   logic              clear_ff,      clear_in;
   logic [CLR_W-1:0]  clr_cnt_ff,    clr_cnt_in;

   logic              s1_valid_ff,   s1_valid_in;
   rrd_info_type      s1_info_ff,    s1_info_in;
   logic              rsp_valid_ff,  rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff,   rsp_data_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   rrd_ram_cmd_type       ram_cmd;
   rrd_rom_cmd_type       rom_cmd;
   rrd_info_type          dec_info;
   logic [LANES-1:0][7:0] ram_lanes;
   logic [LANES-1:0][7:0] rom_lanes;
   logic [DATA_W-1:0]     asm_data;
   logic                  accept;
   logic                  out_free;
   logic                  s1_free;
   logic                  clr_ram_row;
   logic                  clr_rom_row;

   // Register writes.
   always_comb begin
      ram_base_in   = ram_base_ff;
      ram_length_in = ram_length_ff;
      rom_base_in   = rom_base_ff;
      rom_length_in = rom_length_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RAM_BASE:   ram_base_in   = csr_wdata;
            CSR_RAM_LENGTH: ram_length_in = csr_wdata[LEN_W-1:0];
            CSR_ROM_BASE:   rom_base_in   = csr_wdata;
            CSR_ROM_LENGTH: rom_length_in = csr_wdata[LEN_W-1:0];
            default:        ram_base_in   = ram_base_ff;
         endcase
      end
   end

   // Decode of the incoming request.
   rrd_decode u_decode (
      .action     (req_tuser),
      .address    (req_tdata[31:0]),
      .write_data (req_tdata[63:32]),
      .ram_base   (ram_base_ff),
      .ram_length (ram_length_ff),
      .rom_base   (rom_base_ff),
      .rom_length (rom_length_ff),
      .ram_cmd    (ram_cmd),
      .rom_cmd    (rom_cmd),
      .info       (dec_info)
   );

   // Flow control: the memory stage moves on whenever the output register frees.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_free    = !s1_valid_ff || out_free;
   assign req_tready = !clear_ff && s1_free;
   assign accept     = req_tvalid && req_tready;

   // Clearing pass over the rows of both stores.
   assign clr_ram_row = CLR_W'(RAM_ROWS - 1) >= clr_cnt_ff;
   assign clr_rom_row = CLR_W'(ROM_ROWS - 1) >= clr_cnt_ff;

   always_comb begin
      clear_in   = clear_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clear_ff) begin
         clr_cnt_in = clr_cnt_ff + CLR_W'(1);
         if (clr_cnt_ff == CLR_W'(CLR_ROWS - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   // Byte lanes of both stores.
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      rrd_ram #(
         .WIDTH (8),
         .DEPTH (RAM_ROWS)
      ) u_ram_lane (
         .clock   (clock),
         .wr_en   (clear_ff ? clr_ram_row : (accept && ram_cmd.wr && ram_cmd.lane_en[j])),
         .wr_addr (clear_ff ? clr_cnt_ff[RAM_ROW_W-1:0] : ram_cmd.row[j]),
         .wr_data (clear_ff ? 8'h00 : ram_cmd.data[j]),
         .rd_en   (accept),
         .rd_addr (ram_cmd.row[j]),
         .rd_data (ram_lanes[j])
      );

      rrd_ram #(
         .WIDTH (8),
         .DEPTH (ROM_ROWS)
      ) u_rom_lane (
         .clock   (clock),
         .wr_en   (clear_ff ? clr_rom_row : (accept && rom_cmd.wr && rom_cmd.lane_en[j])),
         .wr_addr (clear_ff ? clr_cnt_ff[ROM_ROW_W-1:0] : rom_cmd.row[j]),
         .wr_data (clear_ff ? 8'h00 : rom_cmd.data[j]),
         .rd_en   (accept),
         .rd_addr (rom_cmd.row[j]),
         .rd_data (rom_lanes[j])
      );
   end

   // Response data from the lanes read for the request in the memory stage.
   rrd_assemble u_assemble (
      .info      (s1_info_ff),
      .ram_lanes (ram_lanes),
      .rom_lanes (rom_lanes),
      .read_data (asm_data)
   );

   // Memory stage and output register.
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_info_in    = s1_info_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
         if (s1_valid_ff) begin
            rsp_data_in   = asm_data;
            rsp_status_in = s1_info_ff.status;
         end
      end

      if (accept) begin
         s1_valid_in = 1'b1;
         s1_info_in  = dec_info;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_base_ff   <= '0;
         ram_length_ff <= LEN_W'(65536);
         rom_base_ff   <= '0;
         rom_length_ff <= '0;
         clear_ff      <= 1'b1;
         clr_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ram_base_ff   <= ram_base_in;
         ram_length_ff <= ram_length_in;
         rom_base_ff   <= rom_base_in;
         rom_length_ff <= rom_length_in;
         clear_ff      <= clear_in;
         clr_cnt_ff    <= clr_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_info_ff    <= s1_info_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

FILE: tb/rrd_response_check.sv
`timescale 1ns / 1ps

// Watches the request, response and register ports of the region decoder,
// works out the response that each accepted request should produce and
// compares the responses in order as they are accepted.
module rrd_response_check import rrd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [63:0]       req_tdata,   // address [31:0], write_data [63:32]
   input  logic [ACT_W-1:0]  req_tuser,   // action [2:0]
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [DATA_W-1:0] rsp_tdata,   // read_data [31:0]
   input  logic [STAT_W-1:0] rsp_tuser,   // status [1:0]
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0] csr_wdata,
   output int                fail_count,
   output int                awaiting,
   output int                checked_count,
   output int                unmapped_seen,
   output int                refused_seen,
   output int                past_end_seen
);

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [STAT_W-1:0] status;
   } bus_response_type;

   // Our own copy of the region registers and of both stores.
   logic [ADDR_W-1:0] ram_base_q;
   logic [LEN_W-1:0]  ram_len_q;
   logic [ADDR_W-1:0] rom_base_q;
   logic [LEN_W-1:0]  rom_len_q;
   logic [7:0]        ram_image [RAM_BYTES];
   logic [7:0]        rom_image [ROM_BYTES];

   bus_response_type  due_responses [$];

   // A length beyond the store size is cut back to the store size.
   function automatic logic [31:0] usable_span(input logic [LEN_W-1:0] len,
                                               input int unsigned cap);
      return (len > cap) ? cap : {{(32-LEN_W){1'b0}}, len};
   endfunction

   // Decodes one access, applies its side effects to the stores and returns
   // the response it should get.
   function automatic bus_response_type decode_access(input logic [ACT_W-1:0]  act,
                                                      input logic [ADDR_W-1:0] addr,
                                                      input logic [DATA_W-1:0] wdata);
      logic [31:0]      ram_span;
      logic [31:0]      rom_span;
      logic [31:0]      ram_off;
      logic [31:0]      rom_off;
      logic             hit_ram;
      logic             hit_rom;
      bus_response_type r;
      ram_span = usable_span(ram_len_q, RAM_BYTES);
      rom_span = usable_span(rom_len_q, ROM_BYTES);
      ram_off  = addr - ram_base_q;
      rom_off  = addr - rom_base_q;
      hit_ram  = ram_off < ram_span;
      hit_rom  = rom_off < rom_span;
      r.read_data = '0;
      r.status    = ST_OK;
      case (act)
         ACT_RD_BYTE: begin
            if (hit_ram) r.read_data = {24'd0, ram_image[ram_off]};
            else if (hit_rom) r.read_data = {24'd0, rom_image[rom_off]};
            else begin
               r.read_data = UNMAPPED_BYTE;
               r.status    = ST_UNMAPPED;
            end
         end
         ACT_RD_WORD: begin
            // The region is picked by the lowest byte; the word must fit in it.
            if (hit_ram) begin
               if (ram_off + 32'd3 < ram_span)
                  r.read_data = {ram_image[ram_off + 3], ram_image[ram_off + 2],
                                 ram_image[ram_off + 1], ram_image[ram_off]};
               else r.status = ST_PAST_END;
            end else if (hit_rom) begin
               if (rom_off + 32'd3 < rom_span)
                  r.read_data = {rom_image[rom_off + 3], rom_image[rom_off + 2],
                                 rom_image[rom_off + 1], rom_image[rom_off]};
               else r.status = ST_PAST_END;
            end else r.status = ST_UNMAPPED;
         end
         ACT_WR_BYTE: begin
            if (hit_ram) ram_image[ram_off] = wdata[7:0];
            else if (hit_rom) r.status = ST_ROM_REFUSED;
            else r.status = ST_UNMAPPED;
         end
         ACT_WR_WORD: begin
            if (hit_ram) begin
               if (ram_off + 32'd3 < ram_span) begin
                  for (int k = 0; k < 4; k++) ram_image[ram_off + k] = wdata[8*k +: 8];
               end else r.status = ST_PAST_END;
            end else if (hit_rom) r.status = ST_ROM_REFUSED;
            else r.status = ST_UNMAPPED;
         end
         ACT_LOAD_ROM: begin
            // A load looks at the ROM region alone, whatever RAM covers.
            if (hit_rom) rom_image[rom_off] = wdata[7:0];
            else r.status = ST_UNMAPPED;
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      bus_response_type want;
      if (reset) begin
         due_responses.delete();
         for (int i = 0; i < RAM_BYTES; i++) ram_image[i] = 8'h00;
         for (int i = 0; i < ROM_BYTES; i++) rom_image[i] = 8'h00;
         ram_base_q    = '0;
         ram_len_q     = LEN_W'(RAM_BYTES);
         rom_base_q    = '0;
         rom_len_q     = '0;
         fail_count    = 0;
         checked_count = 0;
         unmapped_seen = 0;
         refused_seen  = 0;
         past_end_seen = 0;
      end else begin
         // Responses are matched before this edge's request is added.
         if (rsp_tvalid && rsp_tready) begin
            if (due_responses.size() == 0) begin
               fail_count++;
               $error("response with none outstanding: read_data %h, status %0d",
                      rsp_tdata, rsp_tuser);
            end else begin
               want = due_responses.pop_front();
               checked_count++;
               if (rsp_tdata !== want.read_data) begin
                  fail_count++;
                  $error("read_data: expected %h, got %h", want.read_data, rsp_tdata);
               end
               if (rsp_tuser !== want.status) begin
                  fail_count++;
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               end
               case (want.status)
                  ST_UNMAPPED:    unmapped_seen++;
                  ST_ROM_REFUSED: refused_seen++;
                  ST_PAST_END:    past_end_seen++;
                  default: ;
               endcase
            end
         end
         // The new request joins the tail of the queue.
         if (req_tvalid && req_tready)
            due_responses.insert(due_responses.size(),
                                 decode_access(req_tuser, req_tdata[31:0],
                                               req_tdata[63:32]));
         if (csr_we) begin
            case (csr_index)
               CSR_RAM_BASE:   ram_base_q = csr_wdata;
               CSR_RAM_LENGTH: ram_len_q  = csr_wdata[LEN_W-1:0];
               CSR_ROM_BASE:   rom_base_q = csr_wdata;
               CSR_ROM_LENGTH: rom_len_q  = csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
      end
      awaiting = due_responses.size();
   end

endmodule

FILE: tb/tb_ram_rom_region_decoder.sv
`timescale 1ns / 1ps

module tb_ram_rom_region_decoder;
   import rrd_pkg::*;

   // First of the three action codes that the block does nothing with.
   localparam logic [ACT_W-1:0] ACT_NONE_FIRST = 3'd5;
   localparam int PHASE_ITEMS = 125;
   localparam int HOLD_AT     = 200;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [63:0]       req_tdata;   // address [31:0], write_data [63:32]
   logic [ACT_W-1:0]  req_tuser;   // action [2:0]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;   // read_data [31:0]
   logic [STAT_W-1:0] rsp_tuser;   // status [1:0]
   logic              csr_we;
   logic [IDX_W-1:0]  csr_index;
   logic [ADDR_W-1:0] csr_wdata;

   int fail_count;
   int awaiting;
   int checked_count;
   int unmapped_seen;
   int refused_seen;
   int past_end_seen;

   // Region settings as last written, used to aim addresses.
   logic [ADDR_W-1:0] cur_ram_base;
   logic [LEN_W-1:0]  cur_ram_len;
   logic [ADDR_W-1:0] cur_rom_base;
   logic [LEN_W-1:0]  cur_rom_len;
   logic              quiet;
   int                settings_used;
   int                cycle_count;

   ram_rom_region_decoder dut (.*);

   rrd_response_check access_check (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Timeout.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Response side: random stalls, and one long hold-off that lets the block
   // fill up and push back on requests.
   initial begin : response_sink
      int gap;
      int taken;
      taken = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 18);
         if (taken == HOLD_AT) gap = HOLD_CYCLES;
         repeat (gap) begin
            rsp_tready <= 1'b0;
            @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         @(negedge clock);
      end
   end

   // Offers one request after a random gap and returns at the falling edge
   // after it was taken.
   task automatic send_request(input logic [ACT_W-1:0]  act,
                               input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] wdata);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 18);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wdata, addr};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   // Rewrites all four region registers once the block has drained.
   task automatic set_regions(input logic [ADDR_W-1:0] rb, input logic [LEN_W-1:0] rl,
                              input logic [ADDR_W-1:0] ob, input logic [LEN_W-1:0] ol);
      req_tvalid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_reg(CSR_RAM_BASE, rb);
      write_reg(CSR_RAM_LENGTH, {{(ADDR_W-LEN_W){1'b0}}, rl});
      write_reg(CSR_ROM_BASE, ob);
      write_reg(CSR_ROM_LENGTH, {{(ADDR_W-LEN_W){1'b0}}, ol});
      csr_we <= 1'b0;
      cur_ram_base = rb;
      cur_ram_len  = rl;
      cur_rom_base = ob;
      cur_rom_len  = ol;
      settings_used++;
   endtask

   // An address in or just around a region, with weight on both ends.
   function automatic logic [ADDR_W-1:0] near_region(input logic [ADDR_W-1:0] base,
                                                     input logic [LEN_W-1:0]  len,
                                                     input int unsigned       cap);
      int unsigned span;
      span = (len > cap) ? cap : len;
      case ($urandom_range(0, 3))
         0, 1:    return base + $urandom_range(0, ((span < 64) ? span : 64) + 3);
         2:       return base + span - $urandom_range(0, 4);
         default: return base + $urandom_range(0, span + 3);
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] pick_address();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return near_region(cur_ram_base, cur_ram_len, RAM_BYTES);
         4, 5, 6:    return near_region(cur_rom_base, cur_rom_len, ROM_BYTES);
         7: begin
            if ($urandom_range(0, 1)) return cur_ram_base - $urandom_range(1, 4);
            return cur_rom_base - $urandom_range(1, 4);
         end
         default:    return $urandom;
      endcase
   endfunction

   function automatic logic [ACT_W-1:0] pick_action();
      int unsigned roll;
      logic [ACT_W-1:0] act;
      roll = $urandom_range(0, 99);
      if (roll < 20) act = ACT_RD_BYTE;
      else if (roll < 40) act = ACT_RD_WORD;
      else if (roll < 55) act = ACT_WR_BYTE;
      else if (roll < 70) act = ACT_WR_WORD;
      else if (roll < 92) act = ACT_LOAD_ROM;
      else act = ACT_NONE_FIRST + ACT_W'($urandom_range(0, 2));
      return act;
   endfunction

   // Mostly short regions so that written bytes are read back often.
   function automatic logic [LEN_W-1:0] pick_length();
      case ($urandom_range(0, 5))
         4:       return LEN_W'(RAM_BYTES);
         5:       return LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
         default: return LEN_W'($urandom_range(0, 80));
      endcase
   endfunction

   task automatic random_batch(input int count);
      for (int i = 0; i < count; i++) send_request(pick_action(), pick_address(), $urandom);
   endtask

   initial begin : stimulus
      logic [ADDR_W-1:0] rb;
      logic [ADDR_W-1:0] ob;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = ACT_RD_BYTE;
      rsp_tready    = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_RAM_BASE;
      csr_wdata     = '0;
      quiet         = 1'b0;
      settings_used = 1;
      cur_ram_base  = '0;
      cur_ram_len   = LEN_W'(RAM_BYTES);
      cur_rom_base  = '0;
      cur_rom_len   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset regions: a word at the very top of RAM, then one byte too far.
      send_request(ACT_WR_WORD, 32'h0000_FFFC, 32'hDEAD_BEEF);
      send_request(ACT_RD_WORD, 32'h0000_FFFD, 32'h0);
      send_request(ACT_RD_WORD, 32'h0000_FFFC, 32'h0);

      // RAM 0x1000..0x10FF overlapping ROM 0x1080..0x127F.
      set_regions(32'h0000_1000, 17'h00100, 32'h0000_1080, 17'h00200);
      send_request(ACT_LOAD_ROM, 32'h0000_1100, 32'h0000_00A5);
      send_request(ACT_LOAD_ROM, 32'h0000_1080, 32'hFFFF_FF5A);
      send_request(ACT_LOAD_ROM, 32'h0000_1280, 32'h0000_0011);
      send_request(ACT_RD_BYTE,  32'h0000_1100, 32'h0);
      send_request(ACT_RD_BYTE,  32'h0000_1080, 32'h0);
      send_request(ACT_WR_WORD,  32'h0000_1000, 32'hFFFF_FFFF);
      send_request(ACT_RD_WORD,  32'h0000_1000, 32'h0);
      send_request(ACT_WR_BYTE,  32'h0000_10FF, 32'h1234_5677);
      send_request(ACT_WR_WORD,  32'h0000_10FD, 32'hCAFE_F00D);
      send_request(ACT_RD_WORD,  32'h0000_10FD, 32'h0);
      send_request(ACT_RD_WORD,  32'h0000_10FC, 32'h0);
      send_request(ACT_WR_BYTE,  32'h0000_1200, 32'h0000_0033);
      send_request(ACT_WR_WORD,  32'h0000_1200, 32'h4444_4444);
      send_request(ACT_RD_WORD,  32'h0000_127D, 32'h0);
      send_request(ACT_RD_WORD,  32'h0000_127C, 32'h0);
      send_request(ACT_RD_BYTE,  32'h0000_0000, 32'h0);
      send_request(ACT_RD_WORD,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(ACT_WR_BYTE,  32'h0000_0FFF, 32'h0000_0099);
      for (int k = 0; k < 3; k++)
         send_request(ACT_NONE_FIRST + ACT_W'(k), 32'h0000_1000, 32'hFFFF_FFFF);
      send_request(ACT_RD_BYTE,  32'h0000_10FF, 32'h0);

      // Random phases, the first few on fixed extreme settings.
      for (int p = 0; p < 10; p++) begin
         quiet = (p % 3 == 1);
         case (p)
            // RAM wraps through address zero, ROM overlaps its tail.
            0: set_regions(32'hFFFF_FFF0, 17'd32, 32'h0000_0008, 17'd32);
            // Lengths beyond the store size, ROM starting at the top address.
            1: set_regions(32'hFFFF_0000, 17'h1FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
            // Empty RAM leaves the whole ROM visible.
            2: set_regions(32'h8000_0000, 17'd0, 32'h8000_0000, 17'h10000);
            // One word exactly fits in each region.
            3: set_regions($urandom, 17'd4, $urandom, 17'd4);
            // No word fits anywhere.
            4: set_regions($urandom, 17'd3, $urandom, 17'd1);
            default: begin
               rb = $urandom;
               ob = $urandom_range(0, 1) ? rb + $urandom_range(0, 64) - 32 : $urandom;
               set_regions(rb, pick_length(), ob, pick_length());
            end
         endcase
         random_batch(PHASE_ITEMS);
      end

      // Drain, then wait for anything unasked for.
      req_tvalid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Compared %0d responses over %0d region settings, edge cases first.",
               checked_count, settings_used);
      $display("Seen %0d unmapped accesses, %0d refused ROM writes, %0d words past an end.",
               unmapped_seen, refused_seen, past_end_seen);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
